// ===== sv/thp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the hop radius counter.
// No dependencies.
package thp_pkg;

  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 2048;
  localparam int NODE_W    = $clog2(MAX_NODES);       // node index
  localparam int NUM_W     = NODE_W + 1;              // node number, 1..MAX_NODES
  localparam int EDGE_W    = $clog2(MAX_EDGES);       // edge slot index
  localparam int PTR_W     = EDGE_W + 1;              // slot plus one, 0 is null
  localparam int DIST_W    = NODE_W;

  localparam logic CMD_ADD_EDGE = 1'b0;
  localparam logic CMD_QUERY    = 1'b1;

  localparam logic [7:0] REG_NODE_COUNT   = 8'd0;
  localparam logic [7:0] REG_MAX_DISTANCE = 8'd1;

  typedef enum logic [3:0] {
    ST_HCLR,
    ST_IDLE,
    ST_E_RA,
    ST_E_WA,
    ST_E_RB,
    ST_E_WB,
    ST_Q_CLR,
    ST_Q_POP,
    ST_Q_U,
    ST_Q_H,
    ST_Q_P,
    ST_Q_T,
    ST_Q_V,
    ST_Q_OUT
  } state_t;

endpackage

// ===== sv/thp_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module thp_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/tree_hop_radius_counter.sv =====
`timescale 1ns / 1ps
// Top level of the hop radius counter: sequencer, adjacency store, walk state.
// Depends on thp_pkg and thp_ram.

// After reset the adjacency heads are swept to null, one node a cycle, so the
// block holds s_tready low until every head is cleared. An edge add takes four
// memory steps on the head store's ports: read and write the head of node a,
// then of node b. A query first clears the visited marks and seeds the start node,
// then walks breadth first: each reached node is popped and its head and distance
// read, and each stored edge direction that the walk scans is read and checked,
// bound by the one read port of each store. One result word per query; edge adds
// give none. Node count and distance limit are written on the cfg channel.
module tree_hop_radius_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // node_a [10:0], node_b [21:11], zero pad
  input  logic [0:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // reach_count [9:0], edges_dropped [10], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import thp_pkg::*;

  state_t state, state_next;

  logic [NUM_W-1:0]  node_count;
  logic [DIST_W-1:0] max_distance;
  logic [PTR_W-1:0]  edge_count;
  logic              overflow;
  logic [NODE_W-1:0] a_q, b_q;
  logic [NUM_W-1:0]  clr;
  logic [NUM_W-1:0]  rd, wr;
  logic [NODE_W-1:0] v_q;
  logic [PTR_W-1:0]  p_q, pn_q;
  logic [DIST_W-1:0] du_q;
  logic [NODE_W-1:0] total;

  // memory ports
  logic              head_we, edge_we, vis_we, dist_we, queue_we;
  logic [NODE_W-1:0] head_wa, head_ra, vis_wa, vis_ra, dist_wa, dist_ra;
  logic [NODE_W-1:0] queue_wa, queue_ra;
  logic [EDGE_W-1:0] edge_wa, edge_ra;
  logic [PTR_W-1:0]  head_wd, head_rd, enext_wd, enext_rd;
  logic [NODE_W-1:0] etgt_wd, etgt_rd, queue_wd, queue_rd;
  logic              vis_wd, vis_rd;
  logic [DIST_W-1:0] dist_wd, dist_rd;

  logic              in_acc;
  logic [NUM_W-1:0]  in_a, in_b;
  logic              in_ok, store_full;
  logic [NUM_W-1:0]  limit;
  logic [DIST_W-1:0] dist_new;
  logic              clr_last;

  assign in_acc     = s_tvalid && s_tready;
  assign in_a       = s_tdata[10:0];
  assign in_b       = s_tdata[21:11];
  assign in_ok      = (in_a != '0) && (in_a <= NUM_W'(MAX_NODES)) &&
                      (in_b != '0) && (in_b <= NUM_W'(MAX_NODES));
  assign store_full = (PTR_W'(MAX_EDGES) - edge_count) < PTR_W'(2);
  assign limit      = (node_count > NUM_W'(MAX_NODES)) ? NUM_W'(MAX_NODES) : node_count;
  assign dist_new   = du_q + DIST_W'(1);
  assign clr_last   = (clr == NUM_W'(MAX_NODES - 1));

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_HCLR:  if (clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (s_tuser[0] == CMD_QUERY) begin
            state_next = ST_Q_CLR;
          end else if (in_ok && !store_full) begin
            state_next = ST_E_RA;
          end
        end
      end
      ST_E_RA:  state_next = ST_E_WA;
      ST_E_WA:  state_next = ST_E_RB;
      ST_E_RB:  state_next = ST_E_WB;
      ST_E_WB:  state_next = ST_IDLE;
      ST_Q_CLR: if (clr == NUM_W'(MAX_NODES)) state_next = ST_Q_POP;
      ST_Q_POP: state_next = (rd == wr) ? ST_Q_OUT : ST_Q_U;
      ST_Q_U:   state_next = ST_Q_H;
      ST_Q_H:   state_next = ST_Q_P;
      ST_Q_P:   state_next = (p_q == '0) ? ST_Q_POP : ST_Q_T;
      ST_Q_T:   state_next = ST_Q_V;
      ST_Q_V:   state_next = ST_Q_P;
      ST_Q_OUT: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    head_we  = 1'b0;
    head_wa  = a_q;
    head_wd  = edge_count + PTR_W'(1);
    head_ra  = a_q;
    edge_we  = 1'b0;
    edge_wa  = edge_count[EDGE_W-1:0];
    edge_ra  = EDGE_W'(p_q - PTR_W'(1));
    etgt_wd  = b_q;
    enext_wd = head_rd;
    vis_we   = 1'b0;
    vis_wa   = v_q;
    vis_wd   = 1'b1;
    vis_ra   = etgt_rd;
    dist_we  = 1'b0;
    dist_wa  = v_q;
    dist_wd  = dist_new;
    dist_ra  = queue_rd;
    queue_we = 1'b0;
    queue_wa = wr[NODE_W-1:0];
    queue_wd = v_q;
    queue_ra = rd[NODE_W-1:0];
    case (state)
      ST_HCLR: begin
        head_we = 1'b1;
        head_wa = clr[NODE_W-1:0];
        head_wd = '0;
      end
      ST_E_RA: head_ra = a_q;
      ST_E_WA: begin
        head_we = 1'b1;
        edge_we = 1'b1;
      end
      ST_E_RB: head_ra = b_q;
      ST_E_WB: begin
        head_we = 1'b1;
        head_wa = b_q;
        edge_we = 1'b1;
        etgt_wd = a_q;
      end
      ST_Q_CLR: begin
        vis_we = 1'b1;
        if (clr == NUM_W'(MAX_NODES)) begin
          // seed the walk with the start node
          vis_wa   = '0;
          vis_wd   = 1'b1;
          dist_we  = 1'b1;
          dist_wa  = '0;
          dist_wd  = '0;
          queue_we = 1'b1;
          queue_wa = '0;
          queue_wd = '0;
        end else begin
          vis_wa = clr[NODE_W-1:0];
          vis_wd = 1'b0;
        end
      end
      ST_Q_U:  head_ra = queue_rd;
      ST_Q_V: begin
        if (!vis_rd) begin
          vis_we   = 1'b1;
          dist_we  = 1'b1;
          queue_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_HCLR;
      node_count   <= NUM_W'(1);
      max_distance <= '0;
      edge_count   <= '0;
      overflow     <= 1'b0;
      clr          <= '0;
      rd           <= '0;
      wr           <= '0;
      total        <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_NODE_COUNT) node_count <= cfg_data[NUM_W-1:0];
        if (cfg_index == REG_MAX_DISTANCE) max_distance <= cfg_data[DIST_W-1:0];
      end
      if (state == ST_Q_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_HCLR: clr <= clr_last ? '0 : clr + NUM_W'(1);
        ST_IDLE: begin
          clr <= '0;
          if (in_acc) begin
            a_q <= NODE_W'(in_a - NUM_W'(1));
            b_q <= NODE_W'(in_b - NUM_W'(1));
            if (s_tuser[0] == CMD_ADD_EDGE && in_ok && store_full) overflow <= 1'b1;
          end
        end
        ST_E_WA, ST_E_WB: edge_count <= edge_count + PTR_W'(1);
        ST_Q_CLR: begin
          clr   <= clr + NUM_W'(1);
          rd    <= '0;
          wr    <= NUM_W'(1);
          total <= '0;
        end
        ST_Q_POP: if (rd != wr) rd <= rd + NUM_W'(1);
        ST_Q_H: begin
          p_q  <= head_rd;
          du_q <= dist_rd;
        end
        ST_Q_T: begin
          v_q  <= etgt_rd;
          pn_q <= enext_rd;
        end
        ST_Q_V: begin
          p_q <= pn_q;
          if (!vis_rd) begin
            wr <= wr + NUM_W'(1);
            if (v_q != '0 && NUM_W'(v_q) < limit && dist_new <= max_distance)
              total <= total + NODE_W'(1);
          end
        end
        ST_Q_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {5'b0, overflow, total};
          end
        end
        default: ;
      endcase
    end
  end

  thp_ram #(.DEPTH(MAX_NODES), .WIDTH(PTR_W)) u_head (
    .clk, .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(head_ra), .rdata(head_rd)
  );
  thp_ram #(.DEPTH(MAX_EDGES), .WIDTH(NODE_W)) u_etgt (
    .clk, .we(edge_we), .waddr(edge_wa), .wdata(etgt_wd), .raddr(edge_ra), .rdata(etgt_rd)
  );
  thp_ram #(.DEPTH(MAX_EDGES), .WIDTH(PTR_W)) u_enext (
    .clk, .we(edge_we), .waddr(edge_wa), .wdata(enext_wd), .raddr(edge_ra), .rdata(enext_rd)
  );
  thp_ram #(.DEPTH(MAX_NODES), .WIDTH(1)) u_vis (
    .clk, .we(vis_we), .waddr(vis_wa), .wdata(vis_wd), .raddr(vis_ra), .rdata(vis_rd)
  );
  thp_ram #(.DEPTH(MAX_NODES), .WIDTH(DIST_W)) u_dist (
    .clk, .we(dist_we), .waddr(dist_wa), .wdata(dist_wd), .raddr(dist_ra), .rdata(dist_rd)
  );
  thp_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_queue (
    .clk, .we(queue_we), .waddr(queue_wa), .wdata(queue_wd), .raddr(queue_ra),
    .rdata(queue_rd)
  );

  a_rd_le_wr: assert property (@(posedge clk) disable iff (rst) rd <= wr)
    else $error("walk queue read pointer passed write pointer");
  a_wr_max: assert property (@(posedge clk) disable iff (rst) wr <= NUM_W'(MAX_NODES))
    else $error("walk queue overrun");
  a_edge_even: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (edge_count[0] == 1'b0 && edge_count <= PTR_W'(MAX_EDGES)))
    else $error("edge store count out of step");
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow |=> overflow)
    else $error("drop flag cleared without reset");

endmodule

// ===== sim/tree_hop_radius_counter_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for tree_hop_radius_counter: directed table, then random edge loads
// and queries, each checked against a breadth-first walk in the bench or a typed row value.
// Depends on thp_pkg and the block's RTL.
module tree_hop_radius_counter_test;
  import thp_pkg::*;

  typedef enum logic [1:0] {ROW_WORD, ROW_CFG, ROW_HOLD} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        cmd;      // for ROW_CFG: unused
    logic [10:0] a;        // for ROW_CFG: register index
    logic [10:0] b;        // for ROW_CFG: value
    bit          typed;
    logic [9:0]  exp_count;
    logic        exp_drop;
  } row_t;

  typedef struct {
    logic [9:0] count;
    logic       drop;
  } reach_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // node_a [10:0], node_b [21:11], zero pad
  logic [0:0]  s_tuser = '0;   // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // reach_count [9:0], edges_dropped [10], zero pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  tree_hop_radius_counter u_dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // graph mirror
  logic [11:0] head_ptr [MAX_NODES];
  logic [9:0]  slot_target [MAX_EDGES];
  logic [11:0] slot_next [MAX_EDGES];
  int unsigned slots_used;
  bit          dropped_seen;
  bit          seen [MAX_NODES];
  int unsigned hops [MAX_NODES];
  int unsigned bfs_fifo [MAX_NODES];
  int unsigned lim_nodes;
  int unsigned lim_hops;

  reach_t pending_reach[$];
  int     errors = 0;
  bit     calm = 1'b0;       // no idling on either side
  bit     hold_req = 1'b0;
  int     hold_left = 0;

  function automatic void store_link(int unsigned from, int unsigned to);
    slot_target[slots_used] = to[9:0];
    slot_next[slots_used] = head_ptr[from];
    head_ptr[from] = 12'(slots_used + 1);
    slots_used++;
  endfunction

  function automatic logic [9:0] walk_count();
    int unsigned rd, wr, u, p, v, top, total;
    rd = 0; wr = 0; total = 0;
    for (int i = 0; i < MAX_NODES; i++) begin
      seen[i] = 0; hops[i] = 0;
    end
    seen[0] = 1;
    bfs_fifo[wr++] = 0;
    while (rd < wr) begin
      u = bfs_fifo[rd++];
      p = head_ptr[u];
      while (p != 0 && p <= slots_used) begin
        v = slot_target[p-1];
        if (!seen[v] && wr < MAX_NODES) begin
          seen[v] = 1;
          hops[v] = hops[u] + 1;
          bfs_fifo[wr++] = v;
        end
        p = slot_next[p-1];
      end
    end
    top = (lim_nodes > MAX_NODES) ? MAX_NODES : lim_nodes;
    for (int k = 2; k <= int'(top); k++)
      if (seen[k-1] && hops[k-1] <= lim_hops) total++;
    if (total > 1023) total = 1023;
    return total[9:0];
  endfunction

  // returns 1 when the word yields a result
  function automatic bit predict_word(logic cmd, logic [10:0] a, logic [10:0] b,
                                      output reach_t r);
    r.count = '0; r.drop = dropped_seen;
    if (cmd == CMD_ADD_EDGE) begin
      if (a == 0 || a > MAX_NODES || b == 0 || b > MAX_NODES) return 0;
      if (MAX_EDGES - slots_used < 2) begin
        dropped_seen = 1;
        return 0;
      end
      store_link(a - 1, b - 1);
      store_link(b - 1, a - 1);
      return 0;
    end
    r.count = walk_count();
    r.drop = dropped_seen;
    return 1;
  endfunction

  task automatic send_word(logic cmd, logic [10:0] a, logic [10:0] b,
                           bit typed, logic [9:0] tc, logic td);
    reach_t r;
    if (!calm && $urandom_range(99) < 30) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {2'b00, b, a};
    do @(posedge clk); while (!s_tready);
    if (predict_word(cmd, a, b, r)) begin
      if (typed) begin
        r.count = tc; r.drop = td;
      end
      pending_reach.push_back(r);
    end
  endtask

  task automatic drain();
    @(negedge clk) s_tvalid <= 1'b0;
    while (pending_reach.size() != 0) @(posedge clk);
    repeat (40) @(negedge clk);   // edge adds still finishing
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
    if (idx == REG_NODE_COUNT) lim_nodes = val[10:0];
    else lim_hops = val[9:0];
  endtask

  task automatic set_limits(logic [15:0] nc, logic [15:0] md);
    drain();
    write_reg(REG_NODE_COUNT, nc);
    write_reg(REG_MAX_DISTANCE, md);
  endtask

  function automatic logic [10:0] pick_node();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 11'($urandom_range(1, 48));
    if (r < 93) return 11'($urandom_range(1, MAX_NODES));
    return 11'($urandom_range(0, 2047));
  endfunction

  task automatic random_run(int n);
    logic [10:0] a;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(24) == 0)
        send_word(CMD_QUERY, 11'($urandom), 11'($urandom), 0, '0, 1'b0);
      else begin
        a = pick_node();
        send_word(CMD_ADD_EDGE, a, ($urandom_range(9) == 0) ? a : pick_node(), 0, '0, 1'b0);
      end
    end
  endtask

  // result sink
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 3000;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else
      m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    reach_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reach.size() == 0) begin
        $error("unexpected result word %h", m_tdata);
        errors++;
      end else begin
        e = pending_reach.pop_front();
        if (m_tdata[9:0] !== e.count) begin
          $error("reach_count expected %0d got %0d", e.count, m_tdata[9:0]);
          errors++;
        end
        if (m_tdata[10] !== e.drop) begin
          $error("edges_dropped expected %0d got %0d", e.drop, m_tdata[10]);
          errors++;
        end
      end
    end
  end

  initial begin
    #100ms;
    $display("tree_hop_radius_counter_test: done, errors");
    $finish;
  end

  row_t plan[$];

  initial begin
    for (int i = 0; i < MAX_NODES; i++) head_ptr[i] = '0;
    slots_used = 0; dropped_seen = 0; lim_nodes = 1; lim_hops = 0;
    plan = '{
      // reset limits: node count one, so nothing counts
      '{ROW_WORD, CMD_QUERY,    11'd0,    11'd0,    1, 10'd0, 1'b0},
      '{ROW_WORD, CMD_ADD_EDGE, 11'd1,    11'd2,    0, 10'd0, 1'b0},
      '{ROW_WORD, CMD_QUERY,    11'h7ff,  11'h7ff,  1, 10'd0, 1'b0},
      '{ROW_CFG,  1'b0,         11'd0,    11'd1024, 0, 10'd0, 1'b0},
      '{ROW_WORD, CMD_QUERY,    11'd0,    11'd0,    1, 10'd0, 1'b0},  // dist limit 0
      '{ROW_CFG,  1'b0,         11'd1,    11'd1023, 0, 10'd0, 1'b0},
      '{ROW_WORD, CMD_ADD_EDGE, 11'd2,    11'd1024, 0, 10'd0, 1'b0},
      '{ROW_WORD, CMD_ADD_EDGE, 11'd5,    11'd5,    0, 10'd0, 1'b0},  // self loop
      '{ROW_WORD, CMD_ADD_EDGE, 11'd0,    11'd3,    0, 10'd0, 1'b0},  // ignored
      '{ROW_WORD, CMD_ADD_EDGE, 11'd3,    11'd1025, 0, 10'd0, 1'b0},  // ignored
      '{ROW_WORD, CMD_ADD_EDGE, 11'h7ff,  11'd1,    0, 10'd0, 1'b0},  // ignored
      '{ROW_WORD, CMD_ADD_EDGE, 11'd1024, 11'd5,    0, 10'd0, 1'b0},
      '{ROW_WORD, CMD_ADD_EDGE, 11'd1,    11'd1,    0, 10'd0, 1'b0},
      '{ROW_WORD, CMD_QUERY,    11'd0,    11'd0,    1, 10'd3, 1'b0},
      '{ROW_CFG,  1'b0,         11'd0,    11'd2047, 0, 10'd0, 1'b0},  // above max
      '{ROW_CFG,  1'b0,         11'd1,    11'd1,    0, 10'd0, 1'b0},
      '{ROW_WORD, CMD_QUERY,    11'd0,    11'd0,    1, 10'd1, 1'b0},
      '{ROW_HOLD, 1'b0,         11'd0,    11'd0,    0, 10'd0, 1'b0},
      '{ROW_WORD, CMD_QUERY,    11'd0,    11'd0,    0, 10'd0, 1'b0},
      '{ROW_WORD, CMD_ADD_EDGE, 11'd3,    11'd4,    0, 10'd0, 1'b0},
      '{ROW_WORD, CMD_ADD_EDGE, 11'd4,    11'd6,    0, 10'd0, 1'b0},
      '{ROW_CFG,  1'b0,         11'd0,    11'd0,    0, 10'd0, 1'b0},
      '{ROW_WORD, CMD_QUERY,    11'd0,    11'd0,    1, 10'd0, 1'b0}
    };
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          drain();
          write_reg(plan[i].a[7:0], 16'(plan[i].b));
        end
        ROW_HOLD: hold_req = 1;
        default: send_word(plan[i].cmd, plan[i].a, plan[i].b,
                           plan[i].typed, plan[i].exp_count, plan[i].exp_drop);
      endcase
    end

    set_limits(16'd1024, 16'd1023);
    random_run(280);
    set_limits(16'd40, 16'd2);
    calm = 1'b1;
    random_run(280);
    calm = 1'b0;
    set_limits(16'd2047, 16'd0);
    hold_req = 1;
    random_run(280);
    set_limits(16'($urandom_range(0, 2047)), 16'($urandom_range(0, 1023)));
    random_run(280);
    set_limits(16'd1, 16'd1023);
    random_run(260);
    set_limits(16'($urandom_range(2, 1024)), 16'($urandom_range(1, 6)));
    random_run(300);
    send_word(CMD_QUERY, '0, '0, 0, '0, 1'b0);
    drain();
    if (errors == 0)
      $display("tree_hop_radius_counter_test: done, clean");
    else
      $display("tree_hop_radius_counter_test: done, errors");
    $finish;
  end

endmodule
